// ===== src/swel_pkg.sv =====
package swel_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LEN  = 1'b0,
        CFG_EVENT_LIMIT = 1'b1
    } cfg_index_t;

    // Register widths and reset values
    localparam int WINDOW_W = 20;
    localparam int LIMIT_W  = 9;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 20'd1;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 9'd256;

    // Saturating drop counter
    localparam int                 COUNT_W   = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    // Result item: dropped in bit 0, drop_count above it, padded to bytes
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 1 - COUNT_W;

endpackage

// ===== src/sliding_window_event_limiter.sv =====
// Sliding-window event limiter. Each input item carries one event timestamp
// (strictly increasing); each result item tells whether the event was dropped
// and gives the running, saturating drop count. An event is dropped when it
// would make event_limit or more accepted events inside any window of
// window_len consecutive time units; otherwise it is accepted and its time is
// stored in a ring of the newest MAX_LIMIT accepted timestamps. A limit of 0
// or 1 drops every event, a limit above MAX_LIMIT acts as MAX_LIMIT and a
// window of 0 acts as 1. Throughput is one item per clock while the result
// is drained: the decision for an item needs a single subtract and compare
// against the oldest relevant ring entry, and that entry is fetched by the
// ring's registered read port, addressed from the write pointer's next value
// so that it is ready for the following item. An item taken moves from the
// input register into the result register, which drives the result output.
// A stalled result holds the input register; once that is full too,
// s_axis_tready drops. Configuration is written through a plain write port;
// the user must write it only while no item is in flight, as the block
// itself does not enforce this. Register 0 is window_len, register 1 is
// event_limit.
module sliding_window_event_limiter #(
    parameter int MAX_LIMIT = 256,
    parameter int TIME_BITS = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    // Configuration write port
    input  logic                                  cfg_wr_en,
    input  logic [swel_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swel_pkg::CFG_DATA_W-1:0]       cfg_data,

    // Event input
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata: event_time, zero padding up to a whole byte
    input  logic [((TIME_BITS+7)/8)*8-1:0]        s_axis_tdata,

    // Result output
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // tdata: dropped [0], drop_count [20:1], zero padding [23:21]
    output logic [swel_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

    localparam int PTR_W = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int CNT_W = $clog2(MAX_LIMIT + 1);
    localparam int LIM_W = (CNT_W > swel_pkg::LIMIT_W) ? CNT_W : swel_pkg::LIMIT_W;
    localparam int CMP_W = (TIME_BITS > swel_pkg::WINDOW_W) ? TIME_BITS : swel_pkg::WINDOW_W;

    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_LIMIT - 1);
    localparam logic [PTR_W:0]   RING_SIZE = (PTR_W+1)'(MAX_LIMIT);
    localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(MAX_LIMIT);
    localparam logic [LIM_W-1:0] LIM_MAX   = LIM_W'(MAX_LIMIT);

    // Configuration registers
    logic [swel_pkg::WINDOW_W-1:0] window_len_reg;
    logic [swel_pkg::LIMIT_W-1:0]  event_limit_reg;

    // Input stage
    logic                 in_valid_reg;
    logic [TIME_BITS-1:0] in_time_reg;

    // Ring state
    logic [TIME_BITS-1:0] ring_mem [MAX_LIMIT];
    logic [TIME_BITS-1:0] oldest_reg;
    logic [PTR_W-1:0]     ptr_reg;
    logic [PTR_W-1:0]     ptr_next;
    logic [CNT_W-1:0]     fill_reg;
    logic [CNT_W-1:0]     fill_next;
    logic [PTR_W-1:0]     rd_addr;
    logic [PTR_W:0]       rd_wrap;

    // Drop counter and result stage
    logic [swel_pkg::COUNT_W-1:0] drop_total_reg;
    logic [swel_pkg::COUNT_W-1:0] drop_total_next;
    logic                         out_valid_reg;
    logic                         out_dropped_reg;
    logic [swel_pkg::COUNT_W-1:0] out_count_reg;

    // Decision
    logic                          advance;
    logic                          accept_evt;
    logic                          drop;
    logic [LIM_W-1:0]              lim_eff;
    logic [LIM_W-1:0]              need;
    logic [PTR_W-1:0]              need_ptr;
    logic [swel_pkg::WINDOW_W-1:0] win;
    logic [TIME_BITS-1:0]          age;
    logic                          window_hit;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg  <= swel_pkg::WINDOW_RESET;
            event_limit_reg <= swel_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (swel_pkg::cfg_index_t'(cfg_index))
                swel_pkg::CFG_WINDOW_LEN:
                    window_len_reg <= cfg_data;
                swel_pkg::CFG_EVENT_LIMIT:
                    event_limit_reg <= cfg_data[swel_pkg::LIMIT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: the input register advances into the result register
    // whenever the result register is empty or being drained.
    // ------------------------------------------------------------------
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_time_reg <= s_axis_tdata[TIME_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Drop decision for the item in the input register. oldest_reg holds
    // the (limit-1)-th newest accepted timestamp; only its age matters.
    // ------------------------------------------------------------------
    always_comb
    begin
        lim_eff = (LIM_W'(event_limit_reg) > LIM_MAX) ? LIM_MAX : LIM_W'(event_limit_reg);
        need    = (lim_eff == '0) ? '0 : lim_eff - LIM_W'(1);
        win     = (window_len_reg == '0) ? swel_pkg::WINDOW_W'(1) : window_len_reg;

        // Age wraps modulo the timestamp range
        age        = in_time_reg - oldest_reg;
        window_hit = CMP_W'(age) < CMP_W'(win);

        if (lim_eff <= LIM_W'(1))
        begin
            drop = 1'b1;
        end
        else
        begin
            drop = (LIM_W'(fill_reg) >= need) && window_hit;
        end

        accept_evt = advance && !drop;
    end

    // ------------------------------------------------------------------
    // Ring pointer, fill level and the read address for the next item
    // ------------------------------------------------------------------
    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (accept_evt)
        begin
            ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
            if (fill_reg != FILL_MAX)
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end

        // need stays below MAX_LIMIT whenever the read data is used
        need_ptr = PTR_W'(need);
        rd_wrap  = {1'b0, ptr_next} + RING_SIZE - {1'b0, need_ptr};
        rd_addr  = (ptr_next >= need_ptr) ? ptr_next - need_ptr : rd_wrap[PTR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    // Ring memory: one write and one registered read per cycle. Forward the
    // timestamp being written when it lands on the slot being read.
    always_ff @(posedge clk)
    begin
        if (accept_evt)
        begin
            ring_mem[ptr_reg] <= in_time_reg;
        end

        if (accept_evt && (ptr_reg == rd_addr))
        begin
            oldest_reg <= in_time_reg;
        end
        else
        begin
            oldest_reg <= ring_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Saturating drop counter and result register
    // ------------------------------------------------------------------
    always_comb
    begin
        drop_total_next = drop_total_reg;
        if (advance && drop && (drop_total_reg != swel_pkg::COUNT_MAX))
        begin
            drop_total_next = drop_total_reg + swel_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            drop_total_reg <= drop_total_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dropped_reg <= drop;
            out_count_reg   <= drop_total_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{swel_pkg::OUT_PAD_W{1'b0}}, out_count_reg, out_dropped_reg};

endmodule

// ===== src/swel_checker.sv =====
module swel_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [swel_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                         in_acc;
    logic                         out_acc;
    logic [1:0]                   pending_reg;
    logic [1:0]                   pending_next;
    logic [swel_pkg::COUNT_W-1:0] last_count_reg;
    logic [swel_pkg::COUNT_W-1:0] out_count;
    logic                         out_dropped;
    logic [swel_pkg::COUNT_W-1:0] expect_count;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign out_acc     = m_axis_tvalid && m_axis_tready;
    assign out_dropped = m_axis_tdata[0];
    assign out_count   = m_axis_tdata[swel_pkg::COUNT_W:1];

    always_comb
    begin
        pending_next = pending_reg;
        if (in_acc && !out_acc)
        begin
            pending_next = pending_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pending_next = pending_reg - 2'd1;
        end

        expect_count = last_count_reg;
        if (out_dropped && (last_count_reg != swel_pkg::COUNT_MAX))
        begin
            expect_count = last_count_reg + swel_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            last_count_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
            begin
                last_count_reg <= out_count;
            end
        end
    end

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or vanished while stalled");

    // No result without an item behind it
    a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result shown with no item in flight");

    // At most the input and result registers are occupied
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 2'd2)
        else $error("more than two items in flight");

    // Drop count steps by the dropped flag and saturates
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> out_count == expect_count)
        else $error("drop count does not follow dropped flags");

endmodule

bind sliding_window_event_limiter swel_checker u_swel_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/sv/drop_decision_checker.sv =====
module drop_decision_checker
    import swel_pkg::*;
#(
    parameter int TIME_BITS  = 20,
    parameter int RING_DEPTH = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,

    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    // tdata: event_time, zero padding up to a whole byte
    input  logic [((TIME_BITS+7)/8)*8-1:0] s_axis_tdata,

    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata: dropped [0], drop_count [20:1], zero padding [23:21]
    input  logic [OUT_TDATA_W-1:0]      m_axis_tdata,

    output int                          fail_count,
    output int                          outstanding,
    output int                          results_checked,
    output int                          drops_checked
);

    typedef struct packed {
        logic               dropped;
        logic [COUNT_W-1:0] total;
    } verdict_t;

    verdict_t owed_verdicts[$];

    // Own copy of the limiter state
    logic [TIME_BITS-1:0] kept_times [RING_DEPTH];
    int unsigned          next_slot;
    int unsigned          kept_fill;
    logic [COUNT_W-1:0]   drop_total;
    logic [WINDOW_W-1:0]  window_len;
    logic [LIMIT_W-1:0]   event_limit;

    initial
    begin
        fail_count      = 0;
        outstanding     = 0;
        results_checked = 0;
        drops_checked   = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= 20)
            $display("MISMATCH result %0d: %s got %0d want %0d",
                     results_checked, what, got, want);
    endtask

    // Decide one event and advance the state as the block should.
    function automatic verdict_t admit_event(input logic [TIME_BITS-1:0] stamp);
        int unsigned          lim;
        int unsigned          win;
        int unsigned          need;
        int unsigned          slot;
        logic [TIME_BITS-1:0] age;
        logic                 drop;
        verdict_t             v;

        lim  = (event_limit > RING_DEPTH) ? RING_DEPTH : event_limit;
        win  = (window_len == 0) ? 1 : window_len;
        drop = (lim <= 1);
        if (!drop)
        begin
            need = lim - 1;
            if (kept_fill >= need)
            begin
                // age wraps modulo the timestamp width
                slot = (next_slot + RING_DEPTH - need) % RING_DEPTH;
                age  = stamp - kept_times[slot];
                drop = (age < win);
            end
        end

        if (drop)
        begin
            if (drop_total != COUNT_MAX)
                drop_total++;
        end
        else
        begin
            kept_times[next_slot] = stamp;
            next_slot = (next_slot + 1) % RING_DEPTH;
            if (kept_fill < RING_DEPTH)
                kept_fill++;
        end

        v.dropped = drop;
        v.total   = drop_total;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            owed_verdicts.delete();
            next_slot   = 0;
            kept_fill   = 0;
            drop_total  = '0;
            window_len  = WINDOW_RESET;
            event_limit = LIMIT_RESET;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_WINDOW_LEN:  window_len  = cfg_data[WINDOW_W-1:0];
                    CFG_EVENT_LIMIT: event_limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_verdicts.size() == 0)
                    report_mismatch("result with no event owed", m_axis_tdata, 0);
                else
                begin
                    want = owed_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want.dropped)
                        report_mismatch("dropped", m_axis_tdata[0], want.dropped);
                    if (m_axis_tdata[COUNT_W:1] !== want.total)
                        report_mismatch("drop_count", m_axis_tdata[COUNT_W:1], want.total);
                    if (m_axis_tdata[OUT_TDATA_W-1:COUNT_W+1] !== '0)
                        report_mismatch("padding", m_axis_tdata[OUT_TDATA_W-1:COUNT_W+1], 0);
                    if (want.dropped)
                        drops_checked++;
                end
                results_checked++;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                want = admit_event(s_axis_tdata[TIME_BITS-1:0]);
                owed_verdicts.insert(owed_verdicts.size(), want);
            end

            outstanding <= owed_verdicts.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    import swel_pkg::*;

    localparam int TIME_BITS  = 20;
    localparam int MAX_LIMIT  = 256;
    localparam int IN_TDATA_W = ((TIME_BITS+7)/8)*8;
    localparam int BLOCK_LEN  = 75;     // random items per configuration
    localparam int NUM_BLOCKS = 12;     // three configurations per idling phase

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata: event_time [19:0], zero padding [23:20]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata: dropped [0], drop_count [20:1], zero padding [23:21]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int outstanding;
    int results_checked;
    int drops_checked;

    // Idling knobs, in percent of cycles
    int gap_pct   = 0;
    int stall_pct = 0;

    logic [TIME_BITS-1:0] stamp = '0;
    int                   events_sent = 0;

    always #5 clk = ~clk;

    sliding_window_event_limiter #(
        .MAX_LIMIT (MAX_LIMIT),
        .TIME_BITS (TIME_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    drop_decision_checker #(
        .TIME_BITS  (TIME_BITS),
        .RING_DEPTH (MAX_LIMIT)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .drops_checked   (drops_checked)
    );

    // Result side: stall at random; stall_pct of zero keeps tready high.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    // Offer one event and hold it until the block takes it. Valid stays high
    // on return so back-to-back items need no extra assignment.
    task automatic send_event(input logic [TIME_BITS-1:0] ts);
        while ($urandom_range(99) < gap_pct)
        begin
            // idle cycle: drop valid and scramble the bus
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(ts);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        events_sent++;
    endtask

    // Lower valid and wait until every owed result is back, then let the
    // two-stage pipeline settle before anything touches the registers.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write window_len, then event_limit, one per cycle.
    task automatic program_limits(input logic [WINDOW_W-1:0] win,
                                  input logic [LIMIT_W-1:0]  lim);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WINDOW_LEN;
        cfg_data  <= win;
        @(posedge clk);
        cfg_index <= CFG_EVENT_LIMIT;
        cfg_data  <= CFG_DATA_W'(lim);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly increasing timestamps spaced around the rate threshold, so the
    // ring fills and the window check flips both ways. A few items repeat
    // the last stamp or jump anywhere, which the block sees as modulo ages.
    task automatic random_events(input int n, input int unsigned win, input int unsigned lim);
        int unsigned eff;
        int unsigned span;
        int unsigned roll;
        eff = (lim > MAX_LIMIT) ? MAX_LIMIT : lim;
        if (eff < 2)
            eff = 2;
        span = ((win == 0) ? 1 : win) * 2 / (eff - 1) + 1;
        if (span > 400000)
            span = 400000;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                stamp = TIME_BITS'($urandom);
            else if (roll >= 7)
                stamp = stamp + TIME_BITS'($urandom_range(span, 1));
            send_event(stamp);
        end
    endtask

    initial
    begin
        int unsigned win;
        int unsigned lim;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset settings: window of one, limit 256; top timestamp and a wrap.
        send_event(20'd0);
        send_event(20'hFFFFF);
        send_event(20'd1);
        wait_idle();

        // Zero window and zero limit: both act as one, so everything drops.
        program_limits(20'd0, 9'd0);
        send_event(20'd10);
        send_event(20'd11);
        wait_idle();

        // Limit of one drops too.
        program_limits(20'hFFFFF, 9'd1);
        send_event(20'd12);
        wait_idle();

        // Widest window with a limit of two; the last stamp goes backward.
        program_limits(20'hFFFFF, 9'd2);
        send_event(20'd20);
        send_event(20'd21);
        send_event(20'hFFFFF);
        send_event(20'd5);
        wait_idle();

        // Narrow window: exact boundary, a repeated stamp, a backward step.
        program_limits(20'd3, 9'd2);
        send_event(20'd100);
        send_event(20'd102);
        send_event(20'd103);
        send_event(20'd103);
        send_event(20'd50);
        wait_idle();

        // Limit beyond the ring depth clamps to it.
        program_limits(20'd5, 9'h1FF);
        send_event(20'd200);
        send_event(20'd201);
        send_event(20'd202);
        wait_idle();

        // Increasing stamps that wrap past the top of the time range.
        program_limits(20'd4, 9'd3);
        send_event(20'hFFFFE);
        send_event(20'hFFFFF);
        send_event(20'd0);
        send_event(20'd2);
        send_event(20'd6);
        wait_idle();

        // ---- random part ----
        // Four idling phases, three configurations each; the first few
        // blocks pin the register extremes, the rest pick at random.
        for (int blk = 0; blk < NUM_BLOCKS; blk++)
        begin
            case (blk / 3)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 62; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 62; end
                default: begin gap_pct = 35; stall_pct = 35; end
            endcase
            case (blk)
                0: begin win = 20'hFFFFF; lim = 256; end
                1: begin win = 1;         lim = 2;   end
                2: begin win = 0;         lim = 1;   end
                3: begin win = 300;       lim = 257; end
                4: begin win = 20'hFFFFF; lim = 2;   end
                5: begin win = 20;        lim = 0;   end
                default:
                begin
                    win = $urandom_range(4000, 1);
                    lim = $urandom_range(64, 2);
                end
            endcase
            program_limits(WINDOW_W'(win), LIMIT_W'(lim));
            random_events(BLOCK_LEN, win, lim);
            wait_idle();
        end

        $display("Summary: %0d events sent, %0d results checked, %0d of them drops",
                 events_sent, results_checked, drops_checked);
        $display("Summary: window/limit extremes, wrapped and repeated stamps, four idling mixes");
        if (outstanding != 0)
            $display("Missing results: %0d events never answered", outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with the heaviest idling.
    initial
    begin
        #2000000;
        $display("Timeout: run did not complete");
        $display("CHECK FAILED");
        $finish;
    end

endmodule
